[design/smsp_pkg.sv]
// Shared types, constants and microcode ROM for the square matrix self-product unit.
package smsp_pkg;

   localparam int DATA_W       = 32;
   localparam int IDX_W        = 6;
   localparam int ACT_W        = 2;
   localparam int SIZE_W       = 7;
   localparam int DEF_MAX_SIZE = 64;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE   = 2'd0,
      ACT_COMPUTE = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FETCH  = 3'd0;
   localparam step_type STEP_LOOP   = 3'd1;
   localparam step_type STEP_DRAIN1 = 3'd2;
   localparam step_type STEP_DRAIN2 = 3'd3;
   localparam step_type STEP_FINISH = 3'd4;

   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_START    = 2'd1,
      COND_MORE     = 2'd2,
      COND_OUT_FREE = 2'd3
   } cond_type;

   // When the condition holds the sequencer jumps to target; otherwise it
   // holds the current step or falls through to the next one.
   typedef struct packed {
      logic     req_ready;
      logic     issue;
      logic     finish;
      cond_type cond;
      logic     hold;
      step_type target;
   } ctl_word_type;

   function automatic ctl_word_type ucode_rom(input step_type step);
      ctl_word_type w;
      unique case (step)
         STEP_FETCH:  w = '{1'b1, 1'b0, 1'b0, COND_START,    1'b1, STEP_LOOP};
         STEP_LOOP:   w = '{1'b0, 1'b1, 1'b0, COND_MORE,     1'b0, STEP_LOOP};
         STEP_DRAIN1: w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS,   1'b0, STEP_DRAIN2};
         STEP_DRAIN2: w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS,   1'b0, STEP_FINISH};
         STEP_FINISH: w = '{1'b0, 1'b0, 1'b1, COND_OUT_FREE, 1'b1, STEP_FETCH};
         default:     w = '{1'b0, 1'b0, 1'b0, COND_ALWAYS,   1'b0, STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

[design/square_matrix_self_product_unit.sv]
// Square matrix self-product unit: entry store, microcoded MAC sequencer and checksum.
// Write and clear transactions produce no result.
// A compute runs n terms (n = effective matrix size), one multiply-accumulate per cycle,
// then drains the pipeline, loads the result register and returns to take the next
// request; a result still waiting on rsp_tready holds the sequencer until it is taken.
// Synchronous active-high reset clears the sequencer, checksum and size (to 64);
// matrix entries are not cleared and must be written before they are read.
module square_matrix_self_product_unit #(
   parameter int MAX_SIZE = smsp_pkg::DEF_MAX_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // row [5:0], col [11:6], value [43:12], zero pad
   input  logic [1:0]  req_tuser,  // action [1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // product [31:0], checksum [63:32]
   // Configuration register.
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata   // matrix_size [6:0]
);

   localparam int DW    = smsp_pkg::DATA_W;
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int KW    = $clog2(MAX_SIZE + 1);
   localparam int CW    = (KW > smsp_pkg::IDX_W) ? KW : smsp_pkg::IDX_W;

   // Request fields.
   logic [smsp_pkg::IDX_W-1:0] req_row;
   logic [smsp_pkg::IDX_W-1:0] req_col;
   logic [DW-1:0]              req_value;

   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_value = req_tdata[43:12];

   // Configuration and effective size.
   logic [smsp_pkg::SIZE_W-1:0] size_ff;
   logic [KW-1:0]               n_eff;

   always_comb begin
      priority if (size_ff == '0) begin
         n_eff = KW'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         n_eff = KW'(MAX_SIZE);
      end else begin
         n_eff = KW'(size_ff);
      end
   end

   // Sequencer.
   smsp_pkg::step_type     pc_ff;
   smsp_pkg::step_type     pc_in;
   smsp_pkg::ctl_word_type ctl;
   logic                   cond_true;

   logic                   accept;
   logic                   in_range;
   logic                   start;
   logic                   wr_en;
   logic                   clr_en;
   logic                   out_free;
   logic                   load_out;

   logic [KW-1:0]          cnt_ff;
   logic [KW-1:0]          cnt_in;
   logic [KW-1:0]          cnt_next;
   logic [KW-1:0]          row_ff;
   logic [KW-1:0]          col_ff;

   assign ctl        = smsp_pkg::ucode_rom(pc_ff);
   assign req_tready = ctl.req_ready;
   assign accept     = req_tvalid & ctl.req_ready;
   assign in_range   = (CW'(req_row) < CW'(n_eff)) && (CW'(req_col) < CW'(n_eff));
   assign start      = accept && (req_tuser == smsp_pkg::ACT_COMPUTE) && in_range;
   assign wr_en      = accept && (req_tuser == smsp_pkg::ACT_WRITE) && in_range;
   assign clr_en     = accept && (req_tuser == smsp_pkg::ACT_CLEAR);
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign load_out   = ctl.finish && out_free;
   assign cnt_next   = KW'(cnt_ff + KW'(1));

   always_comb begin
      unique case (ctl.cond)
         smsp_pkg::COND_ALWAYS:   cond_true = 1'b1;
         smsp_pkg::COND_START:    cond_true = start;
         smsp_pkg::COND_MORE:     cond_true = cnt_next < n_eff;
         smsp_pkg::COND_OUT_FREE: cond_true = out_free;
         default:                 cond_true = 1'b0;
      endcase
   end

   always_comb begin
      priority if (cond_true) begin
         pc_in = ctl.target;
      end else if (ctl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = smsp_pkg::step_type'(pc_ff + 3'd1);
      end
   end

   always_comb begin
      priority if (start) begin
         cnt_in = '0;
      end else if (ctl.issue) begin
         cnt_in = cnt_next;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Entry memory: one write port, two registered read ports.
   logic [DW-1:0] mem [DEPTH];
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [DW-1:0] a_rd_ff;
   logic [DW-1:0] b_rd_ff;

   assign wr_addr   = AW'(AW'(req_row) * AW'(MAX_SIZE) + AW'(req_col));
   assign rd_addr_a = AW'(AW'(row_ff) * AW'(MAX_SIZE) + AW'(cnt_ff));
   assign rd_addr_b = AW'(AW'(cnt_ff) * AW'(MAX_SIZE) + AW'(col_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_value;
      end
      if (ctl.issue) begin
         a_rd_ff <= mem[rd_addr_a];
         b_rd_ff <= mem[rd_addr_b];
      end
   end

   // Multiply-accumulate pipeline.
   logic          rd_v_ff;
   logic          mul_v_ff;
   logic [DW-1:0] prod_ff;
   logic [DW-1:0] acc_ff;
   logic [DW-1:0] sum_ff;
   logic [DW-1:0] sum_in;
   logic [DW-1:0] rsp_product_ff;
   logic [DW-1:0] rsp_checksum_ff;
   logic          rsp_valid_ff;

   assign sum_in = DW'(sum_ff + acc_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         row_ff <= KW'(req_row);
         col_ff <= KW'(req_col);
      end
      if (rd_v_ff) begin
         prod_ff <= DW'(a_rd_ff * b_rd_ff);
      end
      if (load_out) begin
         rsp_product_ff  <= acc_ff;
         rsp_checksum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= smsp_pkg::STEP_FETCH;
         size_ff      <= smsp_pkg::SIZE_RESET;
         cnt_ff       <= '0;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         acc_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         rd_v_ff  <= ctl.issue;
         mul_v_ff <= rd_v_ff;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
         if (start) begin
            acc_ff <= '0;
         end else if (mul_v_ff) begin
            acc_ff <= DW'(acc_ff + prod_ff);
         end
         if (clr_en) begin
            sum_ff <= '0;
         end else if (load_out) begin
            sum_ff <= sum_in;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_checksum_ff, rsp_product_ff};

   // A read is only issued for a term inside the matrix.
   assert property (@(posedge clock) disable iff (reset)
      ctl.issue |-> cnt_ff < n_eff)
      else $error("term read issued past the matrix size");

   // A started compute enters the loop with the term counter cleared.
   assert property (@(posedge clock) disable iff (reset)
      start |=> (pc_ff == smsp_pkg::STEP_LOOP) && (cnt_ff == '0))
      else $error("compute did not enter the loop cleanly");

   // By the finish step the pipeline has drained and every term was counted.
   assert property (@(posedge clock) disable iff (reset)
      (pc_ff == smsp_pkg::STEP_FINISH) |-> !rd_v_ff && !mul_v_ff && (cnt_ff == n_eff))
      else $error("finish reached with terms still in flight");

   // A result is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten");

endmodule
